// ----- hw/rtl/ita_pkg.sv -----
// shared types, constants and character helpers for the integer-to-ascii formatter
package ita_pkg;

    localparam int ValueW    = 64;
    localparam int DecDigits = 20;
    localparam int DigW      = DecDigits * 4;
    localparam int StepW     = $clog2(ValueW);
    localparam int CntW      = 7;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharX     = 8'h78;
    localparam logic [7:0] CharB     = 8'h62;

    localparam logic [7:0] DigitSet [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [1:0]        radix;
        logic              as_unsigned;
        logic              narrow;
    } req_t;

    typedef struct packed {
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic       second_valid;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ch_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DigitSet[d];
    endfunction

endpackage

// ----- hw/rtl/ita_dabble.sv -----
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
module ita_dabble
    import ita_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ValueW-1:0] mag,
    output logic              done,
    output logic [DigW-1:0]   bcd
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [StepW-1:0]  cnt_reg;
    logic [StepW-1:0]  cnt_next;
    logic [ValueW-1:0] bin_reg;
    logic [ValueW-1:0] bin_next;
    logic [DigW-1:0]   bcd_reg;
    logic [DigW-1:0]   bcd_next;
    logic [DigW-1:0]   adj;

    always_comb
    begin
        for (int i = 0; i < DecDigits; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[DigW-2:0], bin_reg[ValueW-1]};
            bin_next = {bin_reg[ValueW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == StepW'(ValueW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- hw/rtl/ita_pair.sv -----
// packs the character stream into two-character result items with an output register
module ita_pair
    import ita_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic ch_valid,
    output logic ch_ready,
    input  ch_t  ch,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic       out_valid_reg;
    logic       out_valid_next;
    rsp_t       out_reg;
    rsp_t       out_next;
    logic       half_valid_reg;
    logic       half_valid_next;
    logic [7:0] half_reg;
    logic [7:0] half_next;
    logic       can_push;

    assign can_push = !out_valid_reg || rsp_ready;
    assign ch_ready = can_push;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        half_valid_next = half_valid_reg;
        half_next       = half_reg;
        if (ch_valid && can_push)
        begin
            if (!half_valid_reg)
            begin
                if (ch.last)
                begin
                    out_next       = '{first_char: ch.ch, second_char: 8'h00,
                                       second_valid: 1'b0, last: 1'b1};
                    out_valid_next = 1'b1;
                end
                else
                begin
                    half_next       = ch.ch;
                    half_valid_next = 1'b1;
                end
            end
            else
            begin
                out_next        = '{first_char: half_reg, second_char: ch.ch,
                                    second_valid: 1'b1, last: ch.last};
                out_valid_next  = 1'b1;
                half_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            half_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            half_valid_reg <= half_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        half_reg <= half_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// top level of the integer-to-ascii formatter: sequencer, prefix and digit shifters
//
// One item is converted at a time; req_ready is high only while the block is idle.
// Hex and binary items go straight to emission, one character per cycle, giving a text
// of 18 or 10 characters for hex and 66 or 34 for binary.
// Decimal items first wait on the shift-and-add-3 converter, then drop leading zero
// digits (up to 19), then emit their characters one per cycle.
// Output stalls hold the emission of characters.
// The output register lets the last result wait while the next item is accepted.
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [15:0]       pre_reg;
    logic [15:0]       pre_next;
    logic [1:0]        pre_cnt_reg;
    logic [1:0]        pre_cnt_next;
    logic [DigW-1:0]   dig_reg;
    logic [DigW-1:0]   dig_next;
    logic [CntW-1:0]   dcnt_reg;
    logic [CntW-1:0]   dcnt_next;
    logic              bit_mode_reg;
    logic              bit_mode_next;

    logic              accept;
    logic              neg;
    logic [ValueW-1:0] mag;
    logic              dab_start;
    logic              dab_done;
    logic [DigW-1:0]   dab_bcd;
    logic              ch_valid;
    logic              ch_ready;
    ch_t               ch;
    logic [7:0]        digit_ch;
    logic [CntW-1:0]   total;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign neg       = !req.as_unsigned && req.value[ValueW-1];
    assign mag       = neg ? (ValueW'(0) - req.value) : req.value;
    assign dab_start = accept && (req.radix == RADIX_DEC);

    ita_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    assign digit_ch = bit_mode_reg ? (CharZero | {7'b0, dig_reg[DigW-1]})
                                   : digit_char(dig_reg[DigW-1 -: 4]);
    assign total    = {{(CntW-2){1'b0}}, pre_cnt_reg} + dcnt_reg;
    assign ch_valid = (state_reg == ST_EMIT);
    assign ch.ch    = (pre_cnt_reg != 2'd0) ? pre_reg[15:8] : digit_ch;
    assign ch.last  = (total == CntW'(1));

    ita_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch_valid  (ch_valid),
        .ch_ready  (ch_ready),
        .ch        (ch),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        pre_next      = pre_reg;
        pre_cnt_next  = pre_cnt_reg;
        dig_next      = dig_reg;
        dcnt_next     = dcnt_reg;
        bit_mode_next = bit_mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.radix)
                        RADIX_DEC:
                        begin
                            pre_next      = {CharMinus, 8'h00};
                            pre_cnt_next  = neg ? 2'd1 : 2'd0;
                            bit_mode_next = 1'b0;
                            state_next    = ST_CONV;
                        end
                        RADIX_HEX:
                        begin
                            pre_next      = {CharZero, CharX};
                            pre_cnt_next  = 2'd2;
                            bit_mode_next = 1'b0;
                            if (req.narrow)
                            begin
                                dig_next  = {req.value[31:0], {(DigW-32){1'b0}}};
                                dcnt_next = CntW'(8);
                            end
                            else
                            begin
                                dig_next  = {req.value, {(DigW-ValueW){1'b0}}};
                                dcnt_next = CntW'(ValueW / 4);
                            end
                            state_next = ST_EMIT;
                        end
                        RADIX_BIN:
                        begin
                            pre_next      = {CharZero, CharB};
                            pre_cnt_next  = 2'd2;
                            bit_mode_next = 1'b1;
                            if (req.narrow)
                            begin
                                dig_next  = {req.value[31:0], {(DigW-32){1'b0}}};
                                dcnt_next = CntW'(32);
                            end
                            else
                            begin
                                dig_next  = {req.value, {(DigW-ValueW){1'b0}}};
                                dcnt_next = CntW'(ValueW);
                            end
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (dab_done)
                begin
                    dig_next   = dab_bcd;
                    dcnt_next  = CntW'(DecDigits);
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (dcnt_reg > CntW'(1) && dig_reg[DigW-1 -: 4] == 4'd0)
                begin
                    dig_next  = {dig_reg[DigW-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (ch_ready)
                begin
                    if (pre_cnt_reg != 2'd0)
                    begin
                        pre_next     = {pre_reg[7:0], 8'h00};
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        if (bit_mode_reg)
                            dig_next = {dig_reg[DigW-2:0], 1'b0};
                        else
                            dig_next = {dig_reg[DigW-5:0], 4'd0};
                        dcnt_next = dcnt_reg - 1'b1;
                    end
                    if (ch.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pre_reg      <= '0;
            pre_cnt_reg  <= '0;
            dig_reg      <= '0;
            dcnt_reg     <= '0;
            bit_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pre_reg      <= pre_next;
            pre_cnt_reg  <= pre_cnt_next;
            dig_reg      <= dig_next;
            dcnt_reg     <= dcnt_next;
            bit_mode_reg <= bit_mode_next;
        end
    end

endmodule

// ----- bench/integer_to_ascii_formatter_checker.sv -----
// checker for the integer-to-ascii formatter: predicts the text of each item and compares pairs
module integer_to_ascii_formatter_checker
    import ita_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] HexAlphaBase = 8'h37;
    localparam int         ReportLimit  = 10;

    rsp_t expected_pairs[$];
    int   fails = 0;

    function automatic void queue_text(input req_t item);
        logic [7:0]  rev [64];
        logic [7:0]  txt [66];
        logic [63:0] mag;
        logic [63:0] rem;
        logic [3:0]  nib;
        logic        neg;
        int          n;
        int          len;
        int          k;
        int          cnt;
        int          pos;
        rsp_t        pair;
        n   = 0;
        len = 0;
        case (item.radix)
            RADIX_DEC:
            begin
                neg = !item.as_unsigned && item.value[63];
                mag = neg ? (64'd0 - item.value) : item.value;
                for (k = 0; k == 0 || mag != 64'd0; k++)
                begin
                    rem    = mag % 64'd10;
                    rev[n] = CharZero + rem[7:0];
                    n++;
                    mag = mag / 64'd10;
                end
                if (neg)
                begin
                    txt[len] = CharMinus;
                    len++;
                end
            end
            RADIX_HEX:
            begin
                cnt = item.narrow ? 8 : 16;
                mag = item.value;
                for (k = 0; k < cnt; k++)
                begin
                    nib    = mag[3:0];
                    rev[n] = (nib < 4'd10) ? CharZero + {4'h0, nib} : HexAlphaBase + {4'h0, nib};
                    n++;
                    mag = mag >> 4;
                end
                txt[0] = CharZero;
                txt[1] = CharX;
                len    = 2;
            end
            RADIX_BIN:
            begin
                cnt = item.narrow ? 32 : 64;
                mag = item.value;
                for (k = 0; k < cnt; k++)
                begin
                    rev[n] = CharZero + {7'h0, mag[0]};
                    n++;
                    mag = mag >> 1;
                end
                txt[0] = CharZero;
                txt[1] = CharB;
                len    = 2;
            end
            default:
                return;
        endcase
        for (k = n - 1; k >= 0; k--)
        begin
            txt[len] = rev[k];
            len++;
        end
        for (pos = 0; pos < len; pos += 2)
        begin
            pair.first_char = txt[pos];
            if (pos + 1 < len)
            begin
                pair.second_char  = txt[pos + 1];
                pair.second_valid = 1'b1;
            end
            else
            begin
                pair.second_char  = 8'h00;
                pair.second_valid = 1'b0;
            end
            pair.last = (pos + 2 >= len);
            expected_pairs.push_back(pair);
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    fails++;
                    if (fails <= ReportLimit)
                        $display("unexpected pair: first=%h second=%h sv=%b last=%b",
                                 rsp.first_char, rsp.second_char, rsp.second_valid, rsp.last);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (rsp.first_char !== want.first_char ||
                        rsp.second_char !== want.second_char ||
                        rsp.second_valid !== want.second_valid ||
                        rsp.last !== want.last)
                    begin
                        fails++;
                        if (fails <= ReportLimit)
                        begin
                            $display("pair mismatch: expected first=%h second=%h sv=%b last=%b",
                                     want.first_char, want.second_char, want.second_valid,
                                     want.last);
                            $display("               got first=%h second=%h sv=%b last=%b",
                                     rsp.first_char, rsp.second_char, rsp.second_valid,
                                     rsp.last);
                        end
                    end
                end
            end
            if (req_valid && req_ready)
                queue_text(req);
            fail_count  <= fails;
            outstanding <= expected_pairs.size();
        end
    end

endmodule

// ----- bench/integer_to_ascii_formatter_tb.sv -----
// testbench top for the integer-to-ascii formatter: clock, reset, stimulus and verdict
module integer_to_ascii_formatter_tb
    import ita_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CycleLimit  = 600000;
    localparam int  RandomItems = 372;
    localparam int  HoldCycles  = 400;
    localparam logic [1:0] RADIX_RESERVED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic quiet;
    logic hold_req;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;

    integer_to_ascii_formatter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    integer_to_ascii_formatter_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else
                rsp_ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    function automatic req_t make_item(input logic [63:0] v, input logic [1:0] radix,
                                       input logic uns, input logic narrow);
        req_t item;
        item.value       = v;
        item.radix       = radix;
        item.as_unsigned = uns;
        item.narrow      = narrow;
        return item;
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = 64'($urandom_range(99));
            1:
            begin
                p = 64'd1;
                k = $urandom_range(19);
                repeat (k) p = p * 64'd10;
                v = p - 64'($urandom_range(1));
            end
            2: v = 64'd0 - 64'($urandom_range(1000));
            3: v = {32'h0, $urandom};
            4: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(3)) - 64'($urandom_range(1));
            default: ;
        endcase
        return v;
    endfunction

    function automatic req_t random_item();
        int          r;
        logic [1:0]  radix;
        r = $urandom_range(99);
        if (r < 4)
            radix = RADIX_RESERVED;
        else if (r < 54)
            radix = RADIX_DEC;
        else if (r < 77)
            radix = RADIX_HEX;
        else
            radix = RADIX_BIN;
        return make_item(pick_value(), radix, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic offer_item(input req_t item);
        int gap;
        if (!quiet && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(1, 50);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic drain_texts();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        req_t directed [$];
        req_t item;
        int   sent;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // decimal extremes, signed and unsigned
        directed.push_back(make_item(64'd0, RADIX_DEC, 1'b0, 1'b0));
        directed.push_back(make_item(64'd0, RADIX_DEC, 1'b1, 1'b1));
        directed.push_back(make_item(64'h8000_0000_0000_0000, RADIX_DEC, 1'b0, 1'b0));
        directed.push_back(make_item(64'h8000_0000_0000_0000, RADIX_DEC, 1'b1, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b0, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b1, 1'b0));
        directed.push_back(make_item(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b0, 1'b1));
        directed.push_back(make_item(64'd9, RADIX_DEC, 1'b0, 1'b0));
        directed.push_back(make_item(64'd10, RADIX_DEC, 1'b1, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFB, RADIX_DEC, 1'b0, 1'b0));
        directed.push_back(make_item(64'd10000000000000000000, RADIX_DEC, 1'b1, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_0000_0007, RADIX_DEC, 1'b1, 1'b1));
        // hex and binary, full and narrow widths, with a signedness flag that must be ignored
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_HEX, 1'b0, 1'b0));
        directed.push_back(make_item(64'h1234_5678_9ABC_DEF0, RADIX_HEX, 1'b1, 1'b1));
        directed.push_back(make_item(64'd0, RADIX_HEX, 1'b1, 1'b0));
        directed.push_back(make_item(64'h8000_0000_0000_0000, RADIX_HEX, 1'b0, 1'b0));
        directed.push_back(make_item(64'hAAAA_AAAA_AAAA_AAAA, RADIX_BIN, 1'b0, 1'b0));
        directed.push_back(make_item(64'h5555_5555_5555_5555, RADIX_BIN, 1'b1, 1'b1));
        directed.push_back(make_item(64'd0, RADIX_BIN, 1'b0, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_BIN, 1'b1, 1'b1));
        // reserved radix produces no text
        directed.push_back(make_item(64'h0123_4567_89AB_CDEF, RADIX_RESERVED, 1'b0, 1'b0));
        directed.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_RESERVED, 1'b1, 1'b1));
        directed.push_back(make_item(64'd42, RADIX_DEC, 1'b0, 1'b0));

        foreach (directed[i])
            offer_item(directed[i]);
        drain_texts();

        sent = 0;
        while (sent < RandomItems)
        begin
            if (sent == 100)
                quiet <= 1'b1;
            if (sent == 180)
                quiet <= 1'b0;
            if (sent == 220)
            begin
                req_valid <= 1'b0;
                hold_req  <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            if (sent == 300 || $urandom_range(99) < 2)
                drain_texts();
            item = random_item();
            offer_item(item);
            if (item.radix != RADIX_RESERVED)
                sent++;
        end

        drain_texts();
        repeat (120) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
